[rtl/cdma_sms_pkg.sv]
// Shared types, codes and per-bit parse helpers for the CDMA SMS PDU decoder.
// Used by the parser, the output queue, the top level and the checker.
// No dependencies.
package cdma_sms_pkg;

    // Result kinds carried on tuser
    localparam logic [1:0] KIND_DIGIT = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_END   = 2'd3;

    // Parameter and subparameter codes
    localparam logic [7:0] PARAM_ORIGIN   = 8'd2;
    localparam logic [7:0] PARAM_BEARER   = 8'd8;
    localparam logic [7:0] SUBP_USER_DATA = 8'd1;
    localparam logic [7:0] SUBP_MSG_WAIT  = 8'd11;

    // Text encodings that carry characters
    localparam logic [4:0] ENC_7BIT_A = 5'd2;
    localparam logic [4:0] ENC_7BIT_B = 5'd3;
    localparam logic [4:0] ENC_OCTET  = 5'd8;

    // Status flag bit positions
    localparam int FLG_VM     = 0;
    localparam int FLG_WAIT   = 1;
    localparam int FLG_SENDER = 2;
    localparam int FLG_TEXT   = 3;

    // Output queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        OUT_HDR,
        OUT_CODE,
        OUT_LEN,
        OUT_BODY
    } outer_t;

    typedef enum logic [1:0] {
        SUB_CODE_ST,
        SUB_LEN_ST,
        SUB_BODY_ST,
        SUB_WAIT_ST
    } sub_t;

    // Bit reader state for one parameter or subparameter body
    typedef struct packed {
        logic [10:0] bit_pos;
        logic [7:0]  shift;
        logic [7:0]  count;
        logic [4:0]  enc;
        logic [2:0]  char_bit;
    } body_t;

    // One result record
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] char_value;
        logic [3:0] flags;
        logic       final_res;
    } rec_t;

    // Result of consuming one bit
    typedef struct packed {
        body_t      body;
        logic       emit;
        logic [1:0] kind;
        logic [7:0] value;
    } step_t;

    // Records pushed into the output queue for one input item
    typedef struct packed {
        logic [1:0] n;
        rec_t       first;
        rec_t       second;
    } push_t;

    // Map a 4-bit address digit to ASCII
    function automatic logic [7:0] digit_char(input logic [3:0] d);
        logic [7:0] c;
        case (d)
            4'd1:    c = 8'h31;
            4'd2:    c = 8'h32;
            4'd3:    c = 8'h33;
            4'd4:    c = 8'h34;
            4'd5:    c = 8'h35;
            4'd6:    c = 8'h36;
            4'd7:    c = 8'h37;
            4'd8:    c = 8'h38;
            4'd9:    c = 8'h39;
            4'd10:   c = 8'h30;
            4'd11:   c = 8'h2A;
            4'd12:   c = 8'h23;
            default: c = 8'h2E;
        endcase
        return c;
    endfunction

    // Consume one bit of an origin address body
    function automatic step_t number_bit(input body_t bd, input logic b);
        step_t r;
        r       = '0;
        r.body  = bd;
        r.kind  = KIND_DIGIT;
        if (bd.bit_pos >= 11'd2 && bd.bit_pos <= 11'd9) begin
            r.body.shift = {bd.shift[6:0], b};
            if (bd.bit_pos == 11'd9) begin
                r.body.count = {bd.shift[6:0], b};
                r.body.shift = '0;
            end
        end else if (bd.bit_pos >= 11'd10 && bd.count != 8'd0) begin
            r.body.shift = {4'd0, bd.shift[2:0], b};
            // a digit closes every fourth bit from position ten
            if (bd.bit_pos[1:0] == 2'd1) begin
                r.emit       = 1'b1;
                r.value      = digit_char({bd.shift[2:0], b});
                r.body.shift = '0;
                r.body.count = bd.count - 8'd1;
            end
        end
        r.body.bit_pos = bd.bit_pos + 11'd1;
        return r;
    endfunction

    // Consume one bit of a user data body
    function automatic step_t text_bit(input body_t bd, input logic b);
        step_t      r;
        logic       ok;
        logic [7:0] nshift;
        logic [2:0] wlast;
        r      = '0;
        r.body = bd;
        ok     = (bd.enc == ENC_7BIT_A) || (bd.enc == ENC_7BIT_B) || (bd.enc == ENC_OCTET);
        nshift = {bd.shift[6:0], b};
        wlast  = (bd.enc == ENC_OCTET) ? 3'd7 : 3'd6;
        if (bd.bit_pos < 11'd5) begin
            r.body.enc = {bd.enc[3:0], b};
        end else if (bd.bit_pos <= 11'd12) begin
            r.body.shift = nshift;
            if (bd.bit_pos == 11'd12) begin
                r.body.count = nshift;
                r.body.shift = '0;
                if (!ok) begin
                    r.emit = 1'b1;
                    r.kind = KIND_BAD;
                end
            end
        end else if (ok && bd.count != 8'd0) begin
            r.body.shift = nshift;
            if (bd.char_bit == wlast) begin
                r.emit          = 1'b1;
                r.kind          = KIND_TEXT;
                r.value         = nshift;
                r.body.shift    = '0;
                r.body.count    = bd.count - 8'd1;
                r.body.char_bit = '0;
            end else begin
                r.body.char_bit = bd.char_bit + 3'd1;
            end
        end
        r.body.bit_pos = bd.bit_pos + 11'd1;
        return r;
    endfunction

endpackage

[rtl/cdma_sms_pdu_decoder_unit.sv]
// Top level of the CDMA SMS PDU decoder: input register, parser, result queue.
// Depends on cdma_sms_pkg, cdma_sms_parse and cdma_sms_ofifo.
//
// Feed the PDU as uppercase ASCII hex characters, one per transfer, with tlast
// on the final character. One character is taken every cycle while the result
// queue has room; each waits in the input register until the parser takes it.
// A character yields at most one digit, text character or bad-encoding marker,
// and the final character adds the end record (tuser = 3, tlast = 1) carrying
// the status flags. The four-entry result queue sets the pace when the output
// side stalls: input is held while fewer than two queue entries are free.
module cdma_sms_pdu_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] hex_char
    input  logic        s_axis_tlast,   // last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] char_value, [8] voicemail, [9] waiting,
                                        // [10] sender_seen, [11] text_seen, [15:12] zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // final_res
);

    logic                in_valid_reg, in_valid_next;
    logic [7:0]          in_char_reg;
    logic                in_last_reg;
    logic                go;
    logic                room;
    cdma_sms_pkg::push_t push;
    cdma_sms_pkg::rec_t  out_rec;

    assign go            = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || go;

    // Hold the input register until the parser takes it
    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
            in_valid_next = 1'b1;
        else if (go)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
    end

    cdma_sms_parse u_parse (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .hex_char (in_char_reg),
        .last     (in_last_reg),
        .push     (push)
    );

    cdma_sms_ofifo u_ofifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_rec   (out_rec)
    );

    // Pack the result record onto the master side
    assign m_axis_tdata = {4'd0, out_rec.flags, out_rec.char_value};
    assign m_axis_tuser = out_rec.kind;
    assign m_axis_tlast = out_rec.final_res;

endmodule

[rtl/cdma_sms_parse.sv]
// PDU parser: turns one registered hex character into at most two result records.
// Depends on cdma_sms_pkg.
module cdma_sms_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 go,
    input  logic [7:0]           hex_char,
    input  logic                 last,
    output cdma_sms_pkg::push_t  push
);

    cdma_sms_pkg::outer_t outer_reg, outer_next;
    cdma_sms_pkg::sub_t   sub_reg, sub_next;
    logic                 nib_phase_reg, nib_phase_next;
    logic [7:0]           param_code_reg, param_code_next;
    logic [7:0]           param_left_reg, param_left_next;
    logic [7:0]           sub_code_reg, sub_code_next;
    logic [7:0]           sub_left_reg, sub_left_next;
    cdma_sms_pkg::body_t  body_reg, body_next;
    logic [3:0]           flags_reg, flags_next;

    logic [3:0]           nib;
    logic                 byte_end;
    logic                 emit_v;
    cdma_sms_pkg::rec_t   emit_rec;
    cdma_sms_pkg::rec_t   end_rec;

    // Decode the character into a nibble
    assign nib      = (hex_char > 8'h39) ? (hex_char[3:0] + 4'd9) : hex_char[3:0];
    assign byte_end = nib_phase_reg;

    // Next state and emitted records
    always_comb
    begin
        cdma_sms_pkg::body_t bd;
        cdma_sms_pkg::step_t sv;
        logic [7:0]          byte_val;
        logic [7:0]          left_val;
        outer_next      = outer_reg;
        sub_next        = sub_reg;
        nib_phase_next  = ~nib_phase_reg;
        param_code_next = param_code_reg;
        param_left_next = param_left_reg;
        sub_code_next   = sub_code_reg;
        sub_left_next   = sub_left_reg;
        body_next       = body_reg;
        flags_next      = flags_reg;
        emit_v          = 1'b0;
        emit_rec        = '0;
        bd              = body_reg;
        sv              = '0;
        byte_val        = {body_reg.shift[3:0], nib};
        left_val        = '0;

        case (outer_reg)
            cdma_sms_pkg::OUT_HDR:
            begin
                if (byte_end)
                    outer_next = cdma_sms_pkg::OUT_CODE;
            end
            cdma_sms_pkg::OUT_CODE:
            begin
                if (!byte_end) begin
                    body_next.shift = {4'd0, nib};
                end else begin
                    param_code_next = byte_val;
                    outer_next      = cdma_sms_pkg::OUT_LEN;
                end
            end
            cdma_sms_pkg::OUT_LEN:
            begin
                if (!byte_end) begin
                    body_next.shift = {4'd0, nib};
                end else begin
                    param_left_next = byte_val;
                    if (param_code_reg == cdma_sms_pkg::PARAM_ORIGIN)
                        flags_next[cdma_sms_pkg::FLG_SENDER] = 1'b1;
                    body_next  = '0;
                    sub_next   = cdma_sms_pkg::SUB_CODE_ST;
                    outer_next = (byte_val == 8'd0) ? cdma_sms_pkg::OUT_CODE
                                                    : cdma_sms_pkg::OUT_BODY;
                end
            end
            default:
            begin
                if (param_code_reg == cdma_sms_pkg::PARAM_ORIGIN) begin
                    // walk the four bits, most significant first
                    for (int i = 0; i < 4; i++) begin
                        sv = cdma_sms_pkg::number_bit(bd, nib[3 - i]);
                        bd = sv.body;
                        if (sv.emit) begin
                            emit_v              = 1'b1;
                            emit_rec.kind       = sv.kind;
                            emit_rec.char_value = sv.value;
                        end
                    end
                    body_next = bd;
                end else if (param_code_reg == cdma_sms_pkg::PARAM_BEARER) begin
                    case (sub_reg)
                        cdma_sms_pkg::SUB_CODE_ST:
                        begin
                            if (!byte_end) begin
                                body_next.shift = {4'd0, nib};
                            end else begin
                                sub_code_next = byte_val;
                                sub_next      = cdma_sms_pkg::SUB_LEN_ST;
                            end
                        end
                        cdma_sms_pkg::SUB_LEN_ST:
                        begin
                            if (!byte_end) begin
                                body_next.shift = {4'd0, nib};
                            end else begin
                                left_val      = byte_val;
                                sub_left_next = left_val;
                                if (sub_code_reg == cdma_sms_pkg::SUBP_USER_DATA)
                                    flags_next[cdma_sms_pkg::FLG_TEXT] = 1'b1;
                                body_next = '0;
                                if (sub_code_reg == cdma_sms_pkg::SUBP_MSG_WAIT &&
                                    left_val == 8'd1) begin
                                    flags_next[cdma_sms_pkg::FLG_VM]   = 1'b1;
                                    flags_next[cdma_sms_pkg::FLG_WAIT] = 1'b0;
                                    sub_next = cdma_sms_pkg::SUB_WAIT_ST;
                                end else begin
                                    sub_next = (left_val == 8'd0) ? cdma_sms_pkg::SUB_CODE_ST
                                                                  : cdma_sms_pkg::SUB_BODY_ST;
                                end
                            end
                        end
                        default:
                        begin
                            if (sub_reg == cdma_sms_pkg::SUB_WAIT_ST) begin
                                // merge the count byte; any set bit means waiting
                                body_next.shift = body_reg.shift | {4'd0, nib};
                                if (byte_end && (body_reg.shift | {4'd0, nib}) != 8'd0)
                                    flags_next[cdma_sms_pkg::FLG_WAIT] = 1'b1;
                            end else if (sub_code_reg == cdma_sms_pkg::SUBP_USER_DATA) begin
                                for (int i = 0; i < 4; i++) begin
                                    sv = cdma_sms_pkg::text_bit(bd, nib[3 - i]);
                                    bd = sv.body;
                                    if (sv.emit) begin
                                        emit_v              = 1'b1;
                                        emit_rec.kind       = sv.kind;
                                        emit_rec.char_value = sv.value;
                                    end
                                end
                                body_next = bd;
                            end
                            if (byte_end) begin
                                sub_left_next = sub_left_reg - 8'd1;
                                if (sub_left_reg == 8'd1)
                                    sub_next = cdma_sms_pkg::SUB_CODE_ST;
                            end
                        end
                    endcase
                end
                if (byte_end) begin
                    param_left_next = param_left_reg - 8'd1;
                    if (param_left_reg == 8'd1)
                        outer_next = cdma_sms_pkg::OUT_CODE;
                end
            end
        endcase

        // The end record reports the flags as left by this character
        end_rec            = '0;
        end_rec.kind       = cdma_sms_pkg::KIND_END;
        end_rec.flags      = flags_next;
        end_rec.final_res  = 1'b1;

        // Drop all parse state at the end of the PDU
        if (last) begin
            outer_next      = cdma_sms_pkg::OUT_HDR;
            sub_next        = cdma_sms_pkg::SUB_CODE_ST;
            nib_phase_next  = 1'b0;
            param_code_next = '0;
            param_left_next = '0;
            sub_code_next   = '0;
            sub_left_next   = '0;
            body_next       = '0;
            flags_next      = '0;
        end
    end

    // Records handed to the output queue
    always_comb
    begin
        push        = '0;
        push.second = end_rec;
        if (go) begin
            push.n     = {1'b0, emit_v} + {1'b0, last};
            push.first = emit_v ? emit_rec : end_rec;
        end
    end

    // Advance the parse state on each processed character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            outer_reg      <= cdma_sms_pkg::OUT_HDR;
            sub_reg        <= cdma_sms_pkg::SUB_CODE_ST;
            nib_phase_reg  <= 1'b0;
            param_code_reg <= '0;
            param_left_reg <= '0;
            sub_code_reg   <= '0;
            sub_left_reg   <= '0;
            body_reg       <= '0;
            flags_reg      <= '0;
        end else if (go) begin
            outer_reg      <= outer_next;
            sub_reg        <= sub_next;
            nib_phase_reg  <= nib_phase_next;
            param_code_reg <= param_code_next;
            param_left_reg <= param_left_next;
            sub_code_reg   <= sub_code_next;
            sub_left_reg   <= sub_left_next;
            body_reg       <= body_next;
            flags_reg      <= flags_next;
        end
    end

endmodule

[rtl/cdma_sms_ofifo.sv]
// Four-entry result queue: takes up to two records a cycle, hands out one while out_ready is high.
// Depends on cdma_sms_pkg.
module cdma_sms_ofifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cdma_sms_pkg::push_t  push,
    output logic                 room,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cdma_sms_pkg::rec_t   out_rec
);

    cdma_sms_pkg::rec_t                  mem [cdma_sms_pkg::FIFO_DEPTH];
    logic [cdma_sms_pkg::FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [cdma_sms_pkg::FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [cdma_sms_pkg::FIFO_CNT_W-1:0] count_reg, count_next;
    logic                                pop;
    logic [cdma_sms_pkg::FIFO_PTR_W-1:0] wr_ptr_inc;

    assign out_valid  = (count_reg != '0);
    assign out_rec    = mem[rd_ptr_reg];
    assign pop        = out_valid && out_ready;
    assign room       = (count_reg <= cdma_sms_pkg::FIFO_CNT_W'(cdma_sms_pkg::FIFO_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + cdma_sms_pkg::FIFO_PTR_W'(1);

    // Pointer and fill bookkeeping
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + cdma_sms_pkg::FIFO_PTR_W'(push.n);
        rd_ptr_next = rd_ptr_reg + cdma_sms_pkg::FIFO_PTR_W'(pop);
        count_next  = count_reg + cdma_sms_pkg::FIFO_CNT_W'(push.n)
                    - cdma_sms_pkg::FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Write the pushed records in order
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            mem[wr_ptr_reg] <= push.first;
        if (push.n == 2'd2)
            mem[wr_ptr_inc] <= push.second;
    end

endmodule

[rtl/cdma_sms_chk.sv]
// Port-level checker for the CDMA SMS PDU decoder, bound to the top level.
// Depends on cdma_sms_pkg.
module cdma_sms_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // A stalled result transfer keeps its contents
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // tlast marks exactly the end record
    a_end_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == cdma_sms_pkg::KIND_END)))
        else $error("tlast and end kind disagree");

    // Flags only appear in the end record
    a_flags_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[15:8] == 8'd0)
        else $error("flags outside end record");

    // Marker and end record carry no character
    a_no_char: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == cdma_sms_pkg::KIND_BAD ||
                          m_axis_tuser == cdma_sms_pkg::KIND_END)
            |-> m_axis_tdata[7:0] == 8'd0)
        else $error("character on marker or end record");

endmodule

bind cdma_sms_pdu_decoder_unit cdma_sms_chk u_chk (.*);

[verif/cdma_sms_pdu_decoder_unit_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for cdma_sms_pdu_decoder_unit: a short directed table, then
// random PDUs, every result checked against a decoder model kept in this file.
// Depends on cdma_sms_pkg and the decoder RTL.
module cdma_sms_pdu_decoder_unit_test;

    localparam int RANDOM_ITEMS = 1950;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int REPORT_LIMIT = 10;
    localparam int DRAIN_CYCLES = 10;

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic [7:0]         ch;
        logic               last;
        logic               typed;
        cdma_sms_pkg::rec_t want;
    } char_row_t;

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'd0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Decoder model state
    logic                 nibble_odd;
    cdma_sms_pkg::outer_t outer_state;
    logic [7:0]           param_code_m;
    logic [7:0]           param_left_m;
    cdma_sms_pkg::sub_t   bearer_state;
    logic [7:0]           sub_code_m;
    logic [7:0]           sub_left_m;
    logic [10:0]          body_bit;
    logic [7:0]           field_acc;
    logic [7:0]           chars_left;
    logic [4:0]           text_enc;
    logic [3:0]           pdu_flags;
    string                digit_glyphs = ".1234567890*#...";

    cdma_sms_pkg::rec_t   char_results[$];   // results of the character just decoded
    cdma_sms_pkg::rec_t   records_due[$];    // results still to leave the decoder

    // Random PDU construction
    logic        body_bits[$];
    logic [7:0]  body_bytes[$];
    logic [7:0]  bearer_bytes[$];
    logic [7:0]  pdu_bytes[$];
    logic [7:0]  pdu_chars[$];

    char_row_t   directed_rows[$];
    int          chars_sent     = 0;
    int          mismatch_count = 0;
    int unsigned cycle_count    = 0;
    logic        send_bursting  = 1'b0;
    logic        sink_bursting  = 1'b0;

    cdma_sms_pdu_decoder_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------

    task automatic clear_decoder();
        nibble_odd   = 1'b0;
        outer_state  = cdma_sms_pkg::OUT_HDR;
        param_code_m = '0;
        param_left_m = '0;
        bearer_state = cdma_sms_pkg::SUB_CODE_ST;
        sub_code_m   = '0;
        sub_left_m   = '0;
        body_bit     = '0;
        field_acc    = '0;
        chars_left   = '0;
        text_enc     = '0;
        pdu_flags    = '0;
    endtask

    task automatic start_field_body();
        body_bit   = '0;
        field_acc  = '0;
        chars_left = '0;
        text_enc   = '0;
    endtask

    task automatic push_result(input logic [1:0] kind, input logic [7:0] value,
                               input logic is_end);
        cdma_sms_pkg::rec_t r;
        r.kind       = kind;
        r.char_value = value;
        r.flags      = is_end ? pdu_flags : 4'd0;
        r.final_res  = is_end;
        char_results.push_back(r);
    endtask

    // Take one bit of an origin address body: two spare bits, count, then digits
    task automatic origin_bit(input logic b);
        if (body_bit >= 11'd2 && body_bit <= 11'd9) begin
            field_acc = {field_acc[6:0], b};
            if (body_bit == 11'd9) begin
                chars_left = field_acc;
                field_acc  = '0;
            end
        end else if (body_bit >= 11'd10 && chars_left != 8'd0) begin
            field_acc = {4'd0, field_acc[2:0], b};
            // close a digit every fourth bit counted from bit ten
            if (((body_bit - 11'd10) & 11'd3) == 11'd3) begin
                push_result(cdma_sms_pkg::KIND_DIGIT, digit_glyphs[field_acc[3:0]], 1'b0);
                field_acc  = '0;
                chars_left = chars_left - 8'd1;
            end
        end
        body_bit = body_bit + 11'd1;
    endtask

    // Take one bit of a user data body: encoding, count, then characters
    task automatic text_bit(input logic b);
        logic known;
        int   width;
        known = (text_enc == cdma_sms_pkg::ENC_7BIT_A) ||
                (text_enc == cdma_sms_pkg::ENC_7BIT_B) ||
                (text_enc == cdma_sms_pkg::ENC_OCTET);
        width = (text_enc == cdma_sms_pkg::ENC_OCTET) ? 8 : 7;
        if (body_bit < 11'd5) begin
            text_enc = {text_enc[3:0], b};
        end else if (body_bit <= 11'd12) begin
            field_acc = {field_acc[6:0], b};
            if (body_bit == 11'd12) begin
                chars_left = field_acc;
                field_acc  = '0;
                if (!known)
                    push_result(cdma_sms_pkg::KIND_BAD, 8'd0, 1'b0);
            end
        end else if (known && chars_left != 8'd0) begin
            field_acc = {field_acc[6:0], b};
            if ((int'(body_bit) - 13) % width == width - 1) begin
                push_result(cdma_sms_pkg::KIND_TEXT, field_acc, 1'b0);
                field_acc  = '0;
                chars_left = chars_left - 8'd1;
            end
        end
        body_bit = body_bit + 11'd1;
    endtask

    // Walk the subparameters of a bearer data body, one nibble at a time
    task automatic bearer_nibble(input logic [3:0] nib, input logic byte_end);
        case (bearer_state)
            cdma_sms_pkg::SUB_CODE_ST: begin
                if (!byte_end) begin
                    field_acc = {4'd0, nib};
                end else begin
                    sub_code_m   = {field_acc[3:0], nib};
                    bearer_state = cdma_sms_pkg::SUB_LEN_ST;
                end
            end
            cdma_sms_pkg::SUB_LEN_ST: begin
                if (!byte_end) begin
                    field_acc = {4'd0, nib};
                end else begin
                    sub_left_m = {field_acc[3:0], nib};
                    if (sub_code_m == cdma_sms_pkg::SUBP_USER_DATA)
                        pdu_flags[cdma_sms_pkg::FLG_TEXT] = 1'b1;
                    start_field_body();
                    if (sub_code_m == cdma_sms_pkg::SUBP_MSG_WAIT && sub_left_m == 8'd1) begin
                        pdu_flags[cdma_sms_pkg::FLG_VM]   = 1'b1;
                        pdu_flags[cdma_sms_pkg::FLG_WAIT] = 1'b0;
                        bearer_state = cdma_sms_pkg::SUB_WAIT_ST;
                    end else begin
                        bearer_state = (sub_left_m == 8'd0) ? cdma_sms_pkg::SUB_CODE_ST
                                                            : cdma_sms_pkg::SUB_BODY_ST;
                    end
                end
            end
            default: begin
                // the waiting count ORs both nibbles together, unshifted
                if (bearer_state == cdma_sms_pkg::SUB_WAIT_ST) begin
                    field_acc = field_acc | {4'd0, nib};
                    if (byte_end && field_acc != 8'd0)
                        pdu_flags[cdma_sms_pkg::FLG_WAIT] = 1'b1;
                end else if (sub_code_m == cdma_sms_pkg::SUBP_USER_DATA) begin
                    for (int i = 3; i >= 0; i--)
                        text_bit(nib[i]);
                end
                if (byte_end) begin
                    sub_left_m = sub_left_m - 8'd1;
                    if (sub_left_m == 8'd0)
                        bearer_state = cdma_sms_pkg::SUB_CODE_ST;
                end
            end
        endcase
    endtask

    // Decode one accepted character into char_results
    task automatic decode_char(input logic [7:0] ch, input logic last);
        logic [3:0] nib;
        logic       byte_end;
        char_results.delete();
        nib      = (ch > 8'h39) ? ch[3:0] + 4'd9 : ch[3:0];
        byte_end = nibble_odd;
        case (outer_state)
            cdma_sms_pkg::OUT_HDR: begin
                if (byte_end)
                    outer_state = cdma_sms_pkg::OUT_CODE;
            end
            cdma_sms_pkg::OUT_CODE: begin
                if (!byte_end) begin
                    field_acc = {4'd0, nib};
                end else begin
                    param_code_m = {field_acc[3:0], nib};
                    outer_state  = cdma_sms_pkg::OUT_LEN;
                end
            end
            cdma_sms_pkg::OUT_LEN: begin
                if (!byte_end) begin
                    field_acc = {4'd0, nib};
                end else begin
                    param_left_m = {field_acc[3:0], nib};
                    if (param_code_m == cdma_sms_pkg::PARAM_ORIGIN)
                        pdu_flags[cdma_sms_pkg::FLG_SENDER] = 1'b1;
                    start_field_body();
                    bearer_state = cdma_sms_pkg::SUB_CODE_ST;
                    outer_state  = (param_left_m == 8'd0) ? cdma_sms_pkg::OUT_CODE
                                                          : cdma_sms_pkg::OUT_BODY;
                end
            end
            default: begin
                if (param_code_m == cdma_sms_pkg::PARAM_ORIGIN) begin
                    for (int i = 3; i >= 0; i--)
                        origin_bit(nib[i]);
                end else if (param_code_m == cdma_sms_pkg::PARAM_BEARER) begin
                    bearer_nibble(nib, byte_end);
                end
                if (byte_end) begin
                    param_left_m = param_left_m - 8'd1;
                    if (param_left_m == 8'd0)
                        outer_state = cdma_sms_pkg::OUT_CODE;
                end
            end
        endcase
        nibble_odd = !nibble_odd;
        // the final character closes the PDU whatever the parse phase
        if (last) begin
            push_result(cdma_sms_pkg::KIND_END, 8'd0, 1'b1);
            clear_decoder();
        end
    endtask

    // ------------------------------------------------------------------
    // Random PDU construction
    // ------------------------------------------------------------------

    task automatic put_bits(input logic [31:0] v, input int w);
        for (int i = w - 1; i >= 0; i--)
            body_bits.push_back(v[i]);
    endtask

    // Pad the bit list with random bits and pack it into body_bytes
    task automatic close_body();
        logic [7:0] octet;
        body_bytes.delete();
        while (body_bits.size() % 8 != 0)
            body_bits.push_back(1'($urandom_range(0, 1)));
        for (int i = 0; i < body_bits.size(); i += 8) begin
            for (int k = 0; k < 8; k++)
                octet[7 - k] = body_bits[i + k];
            body_bytes.push_back(octet);
        end
        body_bits.delete();
    endtask

    task automatic random_body(input int max_len);
        body_bytes.delete();
        repeat ($urandom_range(0, max_len))
            body_bytes.push_back(8'($urandom_range(0, 255)));
    endtask

    // Mostly the true count; now and then more, or the full range
    function automatic int pick_count(input int n);
        case ($urandom_range(0, 7))
            0:       return $urandom_range(0, 255);
            1:       return 255;
            default: return n;
        endcase
    endfunction

    // Mostly the true length; now and then short, so the next field starts early
    function automatic logic [7:0] pick_length(input int n);
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom_range(0, n));
        return 8'(n);
    endfunction

    function automatic logic [7:0] hex_glyph(input logic [3:0] nib);
        if (nib < 4'd10)
            return 8'h30 + {4'd0, nib};
        if ($urandom_range(0, 7) == 0)
            return 8'h61 + {4'd0, nib} - 8'd10;
        return 8'h41 + {4'd0, nib} - 8'd10;
    endfunction

    task automatic emit_field(input logic [7:0] code, input logic into_bearer);
        logic [7:0] declared;
        declared = pick_length(body_bytes.size());
        if (into_bearer) begin
            bearer_bytes.push_back(code);
            bearer_bytes.push_back(declared);
            foreach (body_bytes[i])
                bearer_bytes.push_back(body_bytes[i]);
        end else begin
            pdu_bytes.push_back(code);
            pdu_bytes.push_back(declared);
            foreach (body_bytes[i])
                pdu_bytes.push_back(body_bytes[i]);
        end
    endtask

    task automatic build_origin_body();
        int digits;
        digits = ($urandom_range(0, 15) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 12);
        put_bits($urandom_range(0, 3), 2);
        put_bits(pick_count(digits), 8);
        repeat (digits)
            put_bits($urandom_range(0, 15), 4);
        close_body();
        if ($urandom_range(0, 15) == 0)
            body_bytes.delete();
    endtask

    task automatic build_text_body();
        logic [4:0] enc;
        int         width;
        int         chars;
        case ($urandom_range(0, 9))
            0, 1, 2: enc = cdma_sms_pkg::ENC_7BIT_A;
            3, 4:    enc = cdma_sms_pkg::ENC_7BIT_B;
            5, 6, 7: enc = cdma_sms_pkg::ENC_OCTET;
            default: enc = 5'($urandom_range(0, 31));
        endcase
        width = (enc == cdma_sms_pkg::ENC_OCTET) ? 8 : 7;
        chars = ($urandom_range(0, 15) == 0) ? $urandom_range(30, 120) : $urandom_range(0, 16);
        put_bits(32'(enc), 5);
        put_bits(pick_count(chars), 8);
        repeat (chars)
            put_bits($urandom_range(0, (1 << width) - 1), width);
        close_body();
        if ($urandom_range(0, 15) == 0)
            body_bytes.delete();
    endtask

    task automatic build_bearer_body();
        logic [7:0] code;
        bearer_bytes.delete();
        repeat ($urandom_range(1, 3)) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    code = cdma_sms_pkg::SUBP_USER_DATA;
                    build_text_body();
                end
                5, 6, 7: begin
                    code = cdma_sms_pkg::SUBP_MSG_WAIT;
                    body_bytes.delete();
                    body_bytes.push_back(($urandom_range(0, 2) == 0) ?
                                         8'd0 : 8'($urandom_range(1, 255)));
                    if ($urandom_range(0, 7) == 0)
                        body_bytes.push_back(8'($urandom_range(0, 255)));
                end
                default: begin
                    code = 8'($urandom_range(0, 255));
                    random_body(4);
                end
            endcase
            // keep the bearer body within one length byte
            if (bearer_bytes.size() + body_bytes.size() + 2 <= 255)
                emit_field(code, 1'b1);
        end
        body_bytes = bearer_bytes;
    endtask

    // Fill pdu_chars with one PDU: mostly well formed, some cut short, some noise
    task automatic build_random_pdu();
        int cut;
        pdu_bytes.delete();
        pdu_chars.delete();
        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 24))
                pdu_chars.push_back(8'($urandom_range(0, 255)));
        end else begin
            pdu_bytes.push_back(8'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 4)) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        build_origin_body();
                        emit_field(cdma_sms_pkg::PARAM_ORIGIN, 1'b0);
                    end
                    4, 5, 6, 7: begin
                        build_bearer_body();
                        emit_field(cdma_sms_pkg::PARAM_BEARER, 1'b0);
                    end
                    default: begin
                        random_body(($urandom_range(0, 39) == 0) ? 255 : 6);
                        emit_field(8'($urandom_range(0, 255)), 1'b0);
                    end
                endcase
            end
            foreach (pdu_bytes[i]) begin
                pdu_chars.push_back(hex_glyph(pdu_bytes[i][7:4]));
                pdu_chars.push_back(hex_glyph(pdu_bytes[i][3:0]));
            end
            // end early now and then, often on an odd character
            if ($urandom_range(0, 9) == 0) begin
                cut = $urandom_range(1, pdu_chars.size());
                while (pdu_chars.size() > cut)
                    void'(pdu_chars.pop_back());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one character, wait for its transfer, and queue what it should produce.
    // Enter and leave at a falling edge.
    task automatic offer_char(input logic [7:0] ch, input logic last, input logic typed,
                              input cdma_sms_pkg::rec_t want);
        int pause;
        pause = send_bursting ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0)
            send_bursting = !send_bursting;
        if (pause > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (pause) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        s_axis_tlast  <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        decode_char(ch, last);
        if (typed)
            records_due.push_back(want);
        else
            foreach (char_results[i])
                records_due.push_back(char_results[i]);
        chars_sent++;
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Drop tready for a random pause per transfer; hold off long twice
    initial
    begin : result_sink
        int pause;
        int taken;
        taken = 0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (taken == 100 || taken == 400)
                pause = 150;
            else
                pause = sink_bursting ? 0 : $urandom_range(0, 7);
            if ($urandom_range(0, 63) == 0)
                sink_bursting = !sink_bursting;
            if (pause > 0) begin
                m_axis_tready <= 1'b0;
                repeat (pause) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_axis_tvalid);
            taken++;
        end
    end

    // Compare each result transfer with the oldest outstanding record
    always @(posedge clk)
    begin : result_check
        cdma_sms_pkg::rec_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (records_due.size() == 0) begin
                report_mismatch($sformatf("unexpected result: tuser %0d tdata %h tlast %b",
                                          m_axis_tuser, m_axis_tdata, m_axis_tlast));
            end else begin
                want = records_due.pop_front();
                if (m_axis_tuser != want.kind || m_axis_tdata[7:0] != want.char_value ||
                    m_axis_tdata[11:8] != want.flags || m_axis_tdata[15:12] != 4'd0 ||
                    m_axis_tlast != want.final_res)
                    report_mismatch($sformatf(
                        {"result mismatch (expected/actual): kind %0d/%0d char %h/%h ",
                         "text,sender,wait,vm %b/%b pad 0/%h final %b/%b"},
                        want.kind, m_axis_tuser, want.char_value, m_axis_tdata[7:0],
                        want.flags, m_axis_tdata[11:8], m_axis_tdata[15:12],
                        want.final_res, m_axis_tlast));
            end
        end
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        string              pdu_text;
        cdma_sms_pkg::rec_t end_clear;
        clear_decoder();

        // Directed table. A lone final character gives an end record with no flags.
        // Then a PDU with both header extremes, an origin address whose count runs
        // past its body, and user data whose count also runs past its body.
        end_clear = '{cdma_sms_pkg::KIND_END, 8'h00, 4'h0, 1'b1};
        pdu_text  = "0202016808050103101C1F";
        directed_rows.push_back(char_row_t'{8'hFF, 1'b1, 1'b1, end_clear});
        directed_rows.push_back(char_row_t'{8'h00, 1'b0, 1'b0, cdma_sms_pkg::rec_t'('0)});
        directed_rows.push_back(char_row_t'{8'hFF, 1'b0, 1'b0, cdma_sms_pkg::rec_t'('0)});
        for (int i = 0; i < pdu_text.len(); i++)
            directed_rows.push_back(char_row_t'{8'(pdu_text[i]), i == pdu_text.len() - 1,
                                                1'b0, cdma_sms_pkg::rec_t'('0)});

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_char(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                       directed_rows[i].want);

        // Random PDUs
        while (chars_sent < directed_rows.size() + RANDOM_ITEMS) begin
            build_random_pdu();
            foreach (pdu_chars[i])
                offer_char(pdu_chars[i], i == pdu_chars.size() - 1, 1'b0,
                           cdma_sms_pkg::rec_t'('0));
        end
        s_axis_tvalid <= 1'b0;

        // Drain, then watch for anything stray
        while (records_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
